@@ rtl/kesf_pkg.sv @@
// ----------------------------------------------------------------------------
// kesf_pkg
// Shared types and constants for the key event scanner with event FIFO.
// ----------------------------------------------------------------------------
package kesf_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_NUM_KEYS   = 4;
   localparam int DEF_FIFO_DEPTH = 16;

   // Fixed widths of the channel fields
   localparam int MAX_KEYS   = 4;
   localparam int KEY_W      = 2;
   localparam int KIND_W     = 2;
   localparam int STATE_W    = 2;
   localparam int DROP_W     = 3;
   localparam int COUNT_W    = 8;
   localparam int ENTRY_W    = KEY_W + KIND_W;

   // Events of one tick are spread over this many storage banks
   localparam int BANKS      = 4;
   localparam int BANK_W     = 2;
   localparam int NEV_W      = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_COUNT  = 1'b1;
   localparam logic [COUNT_W-1:0]   PRESS_COUNT_RST = 8'd2;
   localparam logic [COUNT_W-1:0]   LONG_COUNT_RST  = 8'd40;

   // Commands
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Event kinds
   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LONG    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   // FIFO fill state
   localparam logic [STATE_W-1:0] FILL_EMPTY = 2'd0;
   localparam logic [STATE_W-1:0] FILL_PART  = 2'd1;
   localparam logic [STATE_W-1:0] FILL_FULL  = 2'd2;

   // What one key lane found on a tick
   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
   } lane_ev_type;

   // Write request for one storage bank
   typedef struct packed {
      logic               en;
      logic               wrap;   // entry lands on the following row
      logic [ENTRY_W-1:0] data;   // kind in upper bits, key in lower
   } bank_wr_type;

endpackage

@@ rtl/kesf_req_if.sv @@
// ----------------------------------------------------------------------------
// kesf_req_if
// Request channel: scan tick or pop command with key levels.
// ----------------------------------------------------------------------------
interface kesf_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [3:0] key_levels;

   modport source (output valid, output cmd, output key_levels, input ready);
   modport sink   (input valid, input cmd, input key_levels, output ready);
endinterface

@@ rtl/kesf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// kesf_rsp_if
// Response channel: popped event and FIFO status.
// ----------------------------------------------------------------------------
interface kesf_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_valid;
   logic [1:0] event_key;
   logic [1:0] event_kind;
   logic [1:0] fifo_state;
   logic [2:0] events_dropped;

   modport source (output valid, output event_valid, output event_key,
                   output event_kind, output fifo_state, output events_dropped,
                   input ready);
   modport sink   (input valid, input event_valid, input event_key,
                   input event_kind, input fifo_state, input events_dropped,
                   output ready);
endinterface

@@ rtl/key_event_scanner_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// key_event_scanner_fifo_unit
// Key scanner with per-key hold counters and a FIFO of key events.
//
//   port       dir  handshake         payload
//   req_chan   in   valid/ready       cmd, key_levels
//   rsp_chan   out  valid/ready       event_valid, event_key, event_kind,
//                                     fifo_state, events_dropped
//   csr_*      in   csr_wr_en         csr_index, csr_wr_data
//
// One beat per cycle sustained while rsp_chan.ready holds; a response follows its
// request through the bank read stage, then the output register. All keys are
// scanned in parallel lanes; a tick stores up to four events, one per storage
// bank. Reset is synchronous; the event store is not cleared.
// A stalled response backs up through the read stage into req_chan.ready.
// ----------------------------------------------------------------------------
module key_event_scanner_fifo_unit import kesf_pkg::*; #(
   parameter int NUM_KEYS   = DEF_NUM_KEYS,
   parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   kesf_req_if.sink              req_chan,
   kesf_rsp_if.source            rsp_chan
);

   localparam int ROWS  = (FIFO_DEPTH + BANKS - 1) / BANKS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // configuration
   logic [COUNT_W-1:0] press_ff, press_in;
   logic [COUNT_W-1:0] long_ff, long_in;

   // FIFO control
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BANK_W-1:0] wr_bank_ff, wr_bank_in;
   logic [ROW_W-1:0]  wr_row_ff, wr_row_in;
   logic [BANK_W-1:0] rd_bank_ff, rd_bank_in;
   logic [ROW_W-1:0]  rd_row_ff, rd_row_in;

   // read stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_evv_ff, s1_evv_in;
   logic [BANK_W-1:0]  s1_bank_ff, s1_bank_in;
   logic [STATE_W-1:0] s1_state_ff, s1_state_in;
   logic [DROP_W-1:0]  s1_drop_ff, s1_drop_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic               out_evv_ff, out_evv_in;
   logic [KEY_W-1:0]   out_key_ff, out_key_in;
   logic [KIND_W-1:0]  out_kind_ff, out_kind_in;
   logic [STATE_W-1:0] out_state_ff, out_state_in;
   logic [DROP_W-1:0]  out_drop_ff, out_drop_in;

   logic               out_load;
   logic               req_acc;
   logic               tick_go;
   logic               pop_go;
   lane_ev_type        lane_ev [MAX_KEYS];
   bank_wr_type        bank_wr [BANKS];
   logic [NEV_W-1:0]   accepted;
   logic [DROP_W-1:0]  dropped;
   logic [CNT_W-1:0]   free;
   logic [ROW_W-1:0]   wr_row_inc;
   logic [ROW_W-1:0]   rd_row_inc;
   logic [NEV_W-1:0]   wr_sum;
   logic [ENTRY_W-1:0] bank_q [BANKS];
   logic [ENTRY_W-1:0] head_q;
   logic [STATE_W-1:0] state_new;

   // handshake
   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign tick_go        = req_acc && (req_chan.cmd == CMD_TICK);
   assign pop_go         = req_acc && (req_chan.cmd == CMD_POP) && (count_ff != '0);

   // configuration writes
   always_comb begin
      press_in = press_ff;
      long_in  = long_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_PRESS_COUNT: press_in = csr_wr_data;
            REG_LONG_COUNT:  long_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   // key lanes
   for (genvar k = 0; k < MAX_KEYS; k++) begin : g_lane
      if (k < NUM_KEYS) begin : g_on
         kesf_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .tick_en     (tick_go),
            .level       (req_chan.key_levels[k]),
            .press_count (press_ff),
            .long_count  (long_ff),
            .ev          (lane_ev[k])
         );
      end else begin : g_off
         assign lane_ev[k] = '0;
      end
   end

   assign free = CNT_W'(FIFO_DEPTH) - count_ff;

   kesf_merge #(.CNT_W(CNT_W)) u_merge (
      .lane_ev  (lane_ev),
      .wr_bank  (wr_bank_ff),
      .free     (free),
      .bank_wr  (bank_wr),
      .accepted (accepted),
      .dropped  (dropped)
   );

   assign wr_row_inc = (wr_row_ff == ROW_W'(ROWS - 1)) ? '0 : wr_row_ff + ROW_W'(1);
   assign rd_row_inc = (rd_row_ff == ROW_W'(ROWS - 1)) ? '0 : rd_row_ff + ROW_W'(1);

   // event store, interleaved over banks
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      kesf_ram #(.WIDTH(ENTRY_W), .DEPTH(ROWS), .ADDR_W(ROW_W)) u_ram (
         .clock   (clock),
         .wr_en   (tick_go && bank_wr[b].en),
         .wr_addr (bank_wr[b].wrap ? wr_row_inc : wr_row_ff),
         .wr_data (bank_wr[b].data),
         .rd_en   (pop_go && (rd_bank_ff == BANK_W'(b))),
         .rd_addr (rd_row_ff),
         .rd_data (bank_q[b])
      );
   end

   // pointers and fill count
   assign wr_sum = NEV_W'(wr_bank_ff) + accepted;

   always_comb begin
      count_in   = count_ff;
      wr_bank_in = wr_bank_ff;
      wr_row_in  = wr_row_ff;
      rd_bank_in = rd_bank_ff;
      rd_row_in  = rd_row_ff;
      if (tick_go) begin
         count_in   = count_ff + CNT_W'(accepted);
         wr_bank_in = wr_sum[BANK_W-1:0];
         wr_row_in  = wr_sum[BANK_W] ? wr_row_inc : wr_row_ff;
      end else if (pop_go) begin
         count_in   = count_ff - CNT_W'(1);
         rd_bank_in = rd_bank_ff + BANK_W'(1);
         rd_row_in  = (rd_bank_ff == BANK_W'(BANKS - 1)) ? rd_row_inc : rd_row_ff;
      end
   end

   always_comb begin
      if (count_in == '0) begin
         state_new = FILL_EMPTY;
      end else if (count_in == CNT_W'(FIFO_DEPTH)) begin
         state_new = FILL_FULL;
      end else begin
         state_new = FILL_PART;
      end
   end

   // read stage
   assign s1_valid_in = req_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
   assign s1_evv_in   = req_acc ? pop_go : s1_evv_ff;
   assign s1_bank_in  = req_acc ? rd_bank_ff : s1_bank_ff;
   assign s1_state_in = req_acc ? state_new : s1_state_ff;
   assign s1_drop_in  = req_acc ? (tick_go ? dropped : '0) : s1_drop_ff;

   // output register
   assign head_q       = bank_q[s1_bank_ff];
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   assign out_evv_in   = out_load ? s1_evv_ff : out_evv_ff;
   assign out_key_in   = out_load ? (s1_evv_ff ? head_q[KEY_W-1:0] : '0) : out_key_ff;
   assign out_kind_in  = out_load ? (s1_evv_ff ? head_q[ENTRY_W-1:KEY_W] : '0)
                                  : out_kind_ff;
   assign out_state_in = out_load ? s1_state_ff : out_state_ff;
   assign out_drop_in  = out_load ? s1_drop_ff : out_drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff     <= PRESS_COUNT_RST;
         long_ff      <= LONG_COUNT_RST;
         count_ff     <= '0;
         wr_bank_ff   <= '0;
         wr_row_ff    <= '0;
         rd_bank_ff   <= '0;
         rd_row_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         press_ff     <= press_in;
         long_ff      <= long_in;
         count_ff     <= count_in;
         wr_bank_ff   <= wr_bank_in;
         wr_row_ff    <= wr_row_in;
         rd_bank_ff   <= rd_bank_in;
         rd_row_ff    <= rd_row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_evv_ff    <= s1_evv_in;
      s1_bank_ff   <= s1_bank_in;
      s1_state_ff  <= s1_state_in;
      s1_drop_ff   <= s1_drop_in;
      out_evv_ff   <= out_evv_in;
      out_key_ff   <= out_key_in;
      out_kind_ff  <= out_kind_in;
      out_state_ff <= out_state_in;
      out_drop_ff  <= out_drop_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.event_valid    = out_evv_ff;
   assign rsp_chan.event_key      = out_key_ff;
   assign rsp_chan.event_kind     = out_kind_ff;
   assign rsp_chan.fifo_state     = out_state_ff;
   assign rsp_chan.events_dropped = out_drop_ff;

endmodule

@@ rtl/kesf_ram.sv @@
// ----------------------------------------------------------------------------
// kesf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kesf_ram #(
   parameter int WIDTH  = 4,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/kesf_lane.sv @@
// ----------------------------------------------------------------------------
// kesf_lane
// One key: hold counter and press / long-press / release detection.
// ----------------------------------------------------------------------------
module kesf_lane import kesf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_en,
   input  logic               level,       // active low
   input  logic [COUNT_W-1:0] press_count,
   input  logic [COUNT_W-1:0] long_count,
   output lane_ev_type        ev
);

   logic [COUNT_W-1:0] hold_ff;
   logic [COUNT_W-1:0] hold_in;
   logic [COUNT_W-1:0] hold_inc;
   logic [COUNT_W-1:0] hold_new;

   assign hold_inc = hold_ff + COUNT_W'(1);

   always_comb begin
      ev       = '0;
      hold_new = hold_ff;
      if (!level) begin
         hold_new = hold_inc;
         if (hold_inc < press_count) begin
            // still debouncing
         end else if (hold_inc == press_count) begin
            ev.valid = 1'b1;
            ev.kind  = KIND_PRESS;
         end else if (hold_inc >= long_count) begin
            ev.valid = 1'b1;
            ev.kind  = KIND_LONG;
            hold_new = '0;
         end
      end else if (hold_ff >= press_count) begin
         ev.valid = 1'b1;
         ev.kind  = KIND_RELEASE;
         hold_new = '0;
      end
   end

   assign hold_in = tick_en ? hold_new : hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else begin
         hold_ff <= hold_in;
      end
   end

endmodule

@@ rtl/kesf_merge.sv @@
// ----------------------------------------------------------------------------
// kesf_merge
// Packs the lane events of one tick in key order onto consecutive FIFO slots,
// limited by the free space, and counts what is dropped.
// ----------------------------------------------------------------------------
module kesf_merge import kesf_pkg::*; #(
   parameter int CNT_W = 5
) (
   input  lane_ev_type       lane_ev [MAX_KEYS],
   input  logic [BANK_W-1:0] wr_bank,
   input  logic [CNT_W-1:0]  free,
   output bank_wr_type       bank_wr [BANKS],
   output logic [NEV_W-1:0]  accepted,
   output logic [DROP_W-1:0] dropped
);

   localparam int XW = (CNT_W > NEV_W) ? CNT_W : NEV_W;

   logic [NEV_W-1:0] pos [MAX_KEYS];
   logic [NEV_W-1:0] n_ev;
   logic [XW-1:0]    free_x;
   logic [XW-1:0]    n_x;

   // slot of each event within this tick
   always_comb begin
      n_ev = '0;
      for (int i = 0; i < MAX_KEYS; i++) begin
         pos[i] = n_ev;
         n_ev   = n_ev + NEV_W'(lane_ev[i].valid);
      end
   end

   assign free_x   = XW'(free);
   assign n_x      = XW'(n_ev);
   assign accepted = (n_x <= free_x) ? n_ev : free_x[NEV_W-1:0];
   assign dropped  = DROP_W'(n_ev - accepted);

   always_comb begin
      logic [BANK_W-1:0] offs;
      for (int b = 0; b < BANKS; b++) begin
         offs         = BANK_W'(b) - wr_bank;
         bank_wr[b]   = '0;
         bank_wr[b].wrap = (BANK_W'(b) < wr_bank);
         for (int i = 0; i < MAX_KEYS; i++) begin
            if (lane_ev[i].valid && pos[i] == NEV_W'(offs) && NEV_W'(offs) < accepted) begin
               bank_wr[b].en   = 1'b1;
               bank_wr[b].data = {lane_ev[i].kind, KEY_W'(i)};
            end
         end
      end
   end

endmodule
